[rtl/axuhf_pkg.sv]
// Package for the AX.25 UI header framer: types, codes and header byte functions.
// No dependencies; compiled first.
package axuhf_pkg;

  localparam int unsigned CALL_W  = 48;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned SSID_W  = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned HDR_LEN = 16;

  localparam logic [BYTE_W-1:0] CTRL_UI   = 8'h03;
  localparam logic [BYTE_W-1:0] PID_NONE  = 8'hF0;
  localparam logic [BYTE_W-1:0] SSID_BASE = 8'h60;
  localparam logic [BYTE_W-1:0] CHAR_SP   = 8'h20;
  localparam logic [LEN_W-1:0]  CALL_MAX  = 3'd6;
  localparam logic [CNT_W-1:0]  CNT_LAST  = 4'(HDR_LEN - 1);

  localparam logic [IDX_W-1:0] REG_DEST_CALL = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEST_LEN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_DEST_SSID = 3'd2;
  localparam logic [IDX_W-1:0] REG_SRC_CALL  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SRC_LEN   = 3'd4;
  localparam logic [IDX_W-1:0] REG_SRC_SSID  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_PAY
  } state_t;

  typedef enum logic [1:0] {
    SEL_HDR,
    SEL_HELD,
    SEL_IN
  } out_sel_t;

  typedef struct packed {
    logic [CALL_W-1:0] dest_call;
    logic [LEN_W-1:0]  dest_len;
    logic [SSID_W-1:0] dest_ssid;
    logic [CALL_W-1:0] src_call;
    logic [LEN_W-1:0]  src_len;
    logic [SSID_W-1:0] src_ssid;
  } cfg_t;

  typedef struct packed {
    logic     hold_in;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_end;
    logic     cnt_clr;
    logic     cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_last;
    logic held_empty;
    logic held_last;
  } sts_t;

  function automatic logic [BYTE_W-1:0] addr_char(
    input logic [CALL_W-1:0] call,
    input logic [LEN_W-1:0]  len,
    input logic [2:0]        pos
  );
    logic [LEN_W-1:0]  n;
    logic [BYTE_W-1:0] c;
    n = (len > CALL_MAX) ? CALL_MAX : len;
    c = CHAR_SP;
    if (pos < n) begin
      unique case (pos)
        3'd0:    c = call[47:40];
        3'd1:    c = call[39:32];
        3'd2:    c = call[31:24];
        3'd3:    c = call[23:16];
        3'd4:    c = call[15:8];
        default: c = call[7:0];
      endcase
      if (c >= 8'h61 && c <= 8'h7A) begin
        c = c - 8'h20;
      end
    end
    return {c[6:0], 1'b0};
  endfunction

  function automatic logic [BYTE_W-1:0] hdr_byte(
    input cfg_t             cfg,
    input logic [CNT_W-1:0] idx
  );
    logic [BYTE_W-1:0] b;
    if (idx < 4'd6) begin
      b = addr_char(cfg.dest_call, cfg.dest_len, idx[2:0]);
    end else if (idx == 4'd6) begin
      b = SSID_BASE | {3'b000, cfg.dest_ssid, 1'b0};
    end else if (idx < 4'd13) begin
      b = addr_char(cfg.src_call, cfg.src_len, 3'(idx - 4'd7));
    end else if (idx == 4'd13) begin
      b = SSID_BASE | {3'b000, cfg.src_ssid, 1'b1};
    end else if (idx == 4'd14) begin
      b = CTRL_UI;
    end else begin
      b = PID_NONE;
    end
    return b;
  endfunction

endpackage

[rtl/axuhf_if.sv]
// Stream interfaces for the framer: payload words in, frame words out.
// Depends on axuhf_pkg.
interface axuhf_in_if;
  import axuhf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic              payload_last;
  logic              empty_frame;
  modport source (output valid, payload_byte, payload_last, empty_frame, input ready);
  modport sink (input valid, payload_byte, payload_last, empty_frame, output ready);
endinterface

interface axuhf_out_if;
  import axuhf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              frame_end;
  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

[rtl/ax25_ui_header_framer_top.sv]
// AX.25 UI header framer, top level: joins controller and datapath.
// Depends on axuhf_pkg, axuhf_if, axuhf_ctrl and axuhf_dp.
//
// in_ch carries payload words (byte, last flag, empty-frame flag); out_ch
// carries frame words (byte, end flag). Both use valid/ready.
// cfg_we/cfg_idx/cfg_wdata write the callsign, length and SSID registers;
// write only while no frame word is pending.
// The first word of a frame is held while the 16 header words go out one per
// cycle from the header counter while the receiver takes them, then the word
// itself follows. A header-only frame ends on the PID word. Words of an open
// frame pass through the output register one per cycle while the receiver
// takes them, each registered in the cycle after accept.
// The header sequencer blocks input at each frame start while the header and
// any held word go out.
// A stalled receiver holds the output register and with it in_ch.ready.
// Reset (rst_n low, synchronous) clears the config registers and header counter
// to zero, closes any open frame and empties the output register.
module ax25_ui_header_framer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  axuhf_in_if.sink                     in_ch,
  axuhf_out_if.source                  out_ch,
  input  logic                         cfg_we,
  input  logic [axuhf_pkg::IDX_W-1:0]  cfg_idx,
  input  logic [axuhf_pkg::CALL_W-1:0] cfg_wdata
);
  import axuhf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  axuhf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.payload_last),
    .in_empty (in_ch.empty_frame),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  axuhf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_byte   (in_ch.payload_byte),
    .in_last   (in_ch.payload_last),
    .in_empty  (in_ch.empty_frame),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.frame_byte),
    .out_end   (out_ch.frame_end),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[rtl/axuhf_ctrl.sv]
// Framer controller: state machine sequencing header and payload words.
// Depends on axuhf_pkg; drives axuhf_dp through cmd_t, reads sts_t.
module axuhf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  input  logic               in_empty,
  output logic               in_ready,
  input  axuhf_pkg::sts_t    sts,
  output axuhf_pkg::cmd_t    cmd
);
  import axuhf_pkg::*;

  state_t state_r, state_nxt;
  logic   hdr_sent_r, hdr_sent_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      hdr_sent_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      hdr_sent_r <= hdr_sent_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    hdr_sent_nxt = hdr_sent_r;
    in_ready     = 1'b0;
    cmd          = '{hold_in: 1'b0, out_load: 1'b0, out_sel: SEL_HDR,
                     out_end: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (hdr_sent_r && !in_empty) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = SEL_IN;
            cmd.out_end  = in_last;
            hdr_sent_nxt = !in_last;
          end else begin
            cmd.hold_in = 1'b1;
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_HDR;
          end
        end
      end
      ST_HDR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_HDR;
          cmd.cnt_inc  = 1'b1;
          if (sts.cnt_last) begin
            cmd.out_end = sts.held_empty;
            if (sts.held_empty) begin
              hdr_sent_nxt = 1'b0;
              state_nxt    = ST_IDLE;
            end else begin
              state_nxt = ST_PAY;
            end
          end
        end
      end
      ST_PAY: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_HELD;
          cmd.out_end  = sts.held_last;
          hdr_sent_nxt = !sts.held_last;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/axuhf_dp.sv]
// Framer datapath: config registers, held input word, header counter, output register.
// Depends on axuhf_pkg; commanded by axuhf_ctrl.
module axuhf_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [axuhf_pkg::IDX_W-1:0]  cfg_idx,
  input  logic [axuhf_pkg::CALL_W-1:0] cfg_wdata,
  input  logic [axuhf_pkg::BYTE_W-1:0] in_byte,
  input  logic                         in_last,
  input  logic                         in_empty,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [axuhf_pkg::BYTE_W-1:0] out_byte,
  output logic                         out_end,
  input  axuhf_pkg::cmd_t              cmd,
  output axuhf_pkg::sts_t              sts
);
  import axuhf_pkg::*;

  cfg_t              cfg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [BYTE_W-1:0] held_byte_r;
  logic              held_last_r;
  logic              held_empty_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_end_r;
  logic [BYTE_W-1:0] out_byte_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DEST_CALL: cfg_r.dest_call <= cfg_wdata;
        REG_DEST_LEN:  cfg_r.dest_len  <= cfg_wdata[LEN_W-1:0];
        REG_DEST_SSID: cfg_r.dest_ssid <= cfg_wdata[SSID_W-1:0];
        REG_SRC_CALL:  cfg_r.src_call  <= cfg_wdata;
        REG_SRC_LEN:   cfg_r.src_len   <= cfg_wdata[LEN_W-1:0];
        REG_SRC_SSID:  cfg_r.src_ssid  <= cfg_wdata[SSID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_in) begin
      held_byte_r  <= in_byte;
      held_last_r  <= in_last;
      held_empty_r <= in_empty;
    end
  end

  always_comb begin
    unique case (cmd.out_sel)
      SEL_HDR:  out_byte_nxt = hdr_byte(cfg_r, cnt_r);
      SEL_HELD: out_byte_nxt = held_byte_r;
      SEL_IN:   out_byte_nxt = in_byte;
      default:  out_byte_nxt = held_byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r <= out_byte_nxt;
      out_end_r  <= cmd.out_end;
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.cnt_last   = (cnt_r == CNT_LAST);
  assign sts.held_empty = held_empty_r;
  assign sts.held_last  = held_last_r;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_end   = out_end_r;

endmodule

[verif/ax25_ui_header_framer_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for ax25_ui_header_framer_top: payload words in, AX.25 UI frame words out.
// Expected frames come from a scoreboard class with its own header predictor.
// Depends on axuhf_pkg, axuhf_if and the framer RTL.
module ax25_ui_header_framer_top_tb;
  import axuhf_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int RAND_PHASES = 6;
  localparam int WORDS_PER_PHASE = 76;
  localparam int SQUEEZE_PHASE = 3;
  localparam int SQUEEZE_CYCLES = 400;

  typedef struct {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_last;
    logic              empty_frame;
  } payload_word_t;

  typedef struct {
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_end;
  } frame_word_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [CALL_W-1:0] data;
  } reg_write_t;

  class ui_frame_checker;
    cfg_t        station;
    bit          frame_open;
    frame_word_t expected_words[$];
    int          mismatches;

    function new();
      station = '0;
      frame_open = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CALL_W-1:0] data);
      case (idx)
        REG_DEST_CALL: station.dest_call = data;
        REG_DEST_LEN:  station.dest_len  = data[LEN_W-1:0];
        REG_DEST_SSID: station.dest_ssid = data[SSID_W-1:0];
        REG_SRC_CALL:  station.src_call  = data;
        REG_SRC_LEN:   station.src_len   = data[LEN_W-1:0];
        REG_SRC_SSID:  station.src_ssid  = data[SSID_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function logic [BYTE_W-1:0] call_char(logic [CALL_W-1:0] call, logic [LEN_W-1:0] len,
                                          int pos);
      logic [BYTE_W-1:0] c;
      int                valid_chars;
      valid_chars = int'((len > CALL_MAX) ? CALL_MAX : len);
      c = CHAR_SP;
      if (pos < valid_chars) begin
        c = call[CALL_W - 1 - 8 * pos -: 8];
        if (c >= 8'h61 && c <= 8'h7a) begin
          c = c - 8'h20;
        end
      end
      return {c[6:0], 1'b0};
    endfunction

    function void push_word(logic [BYTE_W-1:0] b, logic e);
      frame_word_t w;
      w.frame_byte = b;
      w.frame_end = e;
      expected_words = {expected_words, w};
    endfunction

    function void push_address(logic [CALL_W-1:0] call, logic [LEN_W-1:0] len,
                               logic [SSID_W-1:0] ssid, logic ext);
      for (int i = 0; i < 6; i++) begin
        push_word(call_char(call, len, i), 1'b0);
      end
      push_word(SSID_BASE | {3'b000, ssid, ext}, 1'b0);
    endfunction

    function void push_header(logic ends_frame);
      push_address(station.dest_call, station.dest_len, station.dest_ssid, 1'b0);
      push_address(station.src_call, station.src_len, station.src_ssid, 1'b1);
      push_word(CTRL_UI, 1'b0);
      push_word(PID_NONE, ends_frame);
    endfunction

    function void note_payload(payload_word_t w);
      if (w.empty_frame) begin
        push_header(1'b1);
        frame_open = 1'b0;
      end else begin
        if (!frame_open) begin
          push_header(1'b0);
        end
        push_word(w.payload_byte, w.payload_last);
        frame_open = !w.payload_last;
      end
    endfunction

    task report(string what, int got, int want);
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_frame_word(logic [BYTE_W-1:0] b, logic e);
      frame_word_t want;
      if (expected_words.size() == 0) begin
        report("unexpected frame word", b, 0);
      end else begin
        want = expected_words.pop_front();
        if (b !== want.frame_byte) begin
          report("frame_byte", b, want.frame_byte);
        end
        if (e !== want.frame_end) begin
          report("frame_end", e, want.frame_end);
        end
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_idx;
  logic [CALL_W-1:0] cfg_wdata;
  logic              tx_idle;
  logic              rx_idle;
  logic              rx_hold;
  logic              squeeze_req;
  int unsigned       cycle_count;

  payload_word_t     tx_q[$];
  reg_write_t        reg_writes[$];
  ui_frame_checker   board;

  axuhf_in_if  in_ch ();
  axuhf_out_if out_ch ();

  ax25_ui_header_framer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    payload_word_t w;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      w.payload_byte = in_ch.payload_byte;
      w.payload_last = in_ch.payload_last;
      w.empty_frame = in_ch.empty_frame;
      board.note_payload(w);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_frame_word(out_ch.frame_byte, out_ch.frame_end);
    end
  end

  initial begin : tx_drive
    int            gap;
    payload_word_t w;
    gap = 0;
    in_ch.valid <= 1'b0;
    in_ch.payload_byte <= '0;
    in_ch.payload_last <= 1'b0;
    in_ch.empty_frame <= 1'b0;
    forever begin
      @(posedge clk);
      if (!tx_idle) begin
        gap = 0;
      end
      if (rst_n && !(in_ch.valid && !in_ch.ready)) begin
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          gap--;
        end else if (tx_q.size() != 0) begin
          w = tx_q.pop_front();
          in_ch.payload_byte <= w.payload_byte;
          in_ch.payload_last <= w.payload_last;
          in_ch.empty_frame <= w.empty_frame;
          in_ch.valid <= 1'b1;
          if (tx_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  initial begin : rx_drive
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!rx_idle) begin
        stall = 0;
      end
      if (stall == 0 && rx_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 15);
      end
      if (rx_hold || stall != 0) begin
        out_ch.ready <= 1'b0;
        if (stall != 0) begin
          stall--;
        end
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // hold the receiver off long enough to back the block up into its input
  initial begin : squeeze
    rx_hold <= 1'b0;
    @(posedge clk);
    while (!squeeze_req) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic void put_word(logic [BYTE_W-1:0] b, logic last, logic empty);
    payload_word_t w;
    w.payload_byte = b;
    w.payload_last = last;
    w.empty_frame = empty;
    tx_q = {tx_q, w};
  endfunction

  function automatic void stage(logic [IDX_W-1:0] idx, logic [CALL_W-1:0] data);
    reg_write_t r;
    r.idx = idx;
    r.data = data;
    reg_writes = {reg_writes, r};
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CALL_W-1:0] rand_call();
    logic [CALL_W-1:0] call;
    logic [BYTE_W-1:0] c;
    call = '0;
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 3))
        0:       c = BYTE_W'(8'h61 + $urandom_range(0, 25));
        1:       c = BYTE_W'(8'h41 + $urandom_range(0, 25));
        2:       c = BYTE_W'($urandom_range(8'h5f, 8'h7c));
        default: c = rand_byte();
      endcase
      call = {call[CALL_W-9:0], c};
    end
    return call;
  endfunction

  // fill the bits above a narrow register with junk now and then
  function automatic logic [CALL_W-1:0] with_junk(logic [CALL_W-1:0] v, int bits);
    logic [CALL_W-1:0] junk;
    logic [CALL_W-1:0] mask;
    junk = {16'($urandom), 32'($urandom)};
    mask = (48'd1 << bits) - 48'd1;
    if ($urandom_range(0, 2) == 0) begin
      return (junk & ~mask) | (v & mask);
    end
    return v;
  endfunction

  task automatic apply_writes();
    reg_write_t r;
    while (reg_writes.size() != 0) begin
      r = reg_writes.pop_front();
      cfg_we <= 1'b1;
      cfg_idx <= r.idx;
      cfg_wdata <= r.data;
      board.set_reg(r.idx, r.data);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (tx_q.size() != 0 || in_ch.valid || board.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic queue_random_words(int target);
    int queued;
    int len;
    int pick;
    queued = 0;
    while (queued < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        put_word(rand_byte(), 1'($urandom_range(0, 1)), 1'b1);
        queued++;
      end else if (pick == 2) begin
        // abandon a frame partway with an empty-frame word
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          put_word(rand_byte(), 1'b0, 1'b0);
        end
        put_word(rand_byte(), 1'($urandom_range(0, 1)), 1'b1);
        queued += len + 1;
      end else if (pick == 3) begin
        put_word(rand_byte(), 1'($urandom_range(0, 1)), 1'b0);
        queued++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          put_word(rand_byte(), i == len - 1, 1'b0);
        end
        queued += len;
      end
    end
  endtask

  initial begin : stim
    board = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_DEST_CALL;
    cfg_wdata <= '0;
    tx_idle <= 1'b1;
    rx_idle <= 1'b1;
    squeeze_req <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_word(8'hA5, 1'b1, 1'b1);
    put_word(8'h00, 1'b1, 1'b0);
    drain();

    stage(REG_DEST_CALL, 48'h61_7A_60_7B_E1_FF);
    stage(REG_DEST_LEN, 48'd7);
    stage(REG_DEST_SSID, 48'd15);
    stage(REG_SRC_CALL, 48'h4E_30_43_41_4C_4C);
    stage(REG_SRC_LEN, 48'd3);
    stage(REG_SRC_SSID, 48'd0);
    stage(REG_SPARE_LO, '1);
    stage(REG_SPARE_HI, '1);
    apply_writes();
    put_word(8'hFF, 1'b0, 1'b0);
    put_word(8'h80, 1'b0, 1'b0);
    put_word(8'h7F, 1'b0, 1'b0);
    put_word(8'h5A, 1'b1, 1'b1);
    put_word(8'h01, 1'b0, 1'b0);
    put_word(8'hFE, 1'b1, 1'b0);
    put_word(8'h3C, 1'b0, 1'b1);
    drain();

    stage(REG_DEST_CALL, '1);
    stage(REG_DEST_LEN, 48'hFFFF_FFFF_FFF8);
    stage(REG_DEST_SSID, 48'hFFFF_FFFF_FFF0);
    stage(REG_SRC_CALL, 48'h7B_7A_61_60_40_5B);
    stage(REG_SRC_LEN, 48'd6);
    stage(REG_SRC_SSID, '1);
    apply_writes();
    put_word(8'h55, 1'b0, 1'b0);
    put_word(8'hAA, 1'b0, 1'b0);
    put_word(8'h3C, 1'b1, 1'b0);
    put_word(8'h00, 1'b0, 1'b1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      tx_idle <= (p != 1 && p != SQUEEZE_PHASE && p != RAND_PHASES - 1);
      rx_idle <= (p != 1 && p != RAND_PHASES - 1);
      if (p == 0) begin
        stage(REG_DEST_CALL, '1);
        stage(REG_DEST_LEN, '1);
        stage(REG_DEST_SSID, '1);
        stage(REG_SRC_CALL, '1);
        stage(REG_SRC_LEN, '1);
        stage(REG_SRC_SSID, '1);
      end else if (p == 1) begin
        stage(REG_DEST_CALL, '0);
        stage(REG_DEST_LEN, '0);
        stage(REG_DEST_SSID, '0);
        stage(REG_SRC_CALL, '0);
        stage(REG_SRC_LEN, '0);
        stage(REG_SRC_SSID, '0);
      end else begin
        stage(REG_SRC_SSID, with_junk(48'($urandom_range(0, 15)), SSID_W));
        stage(REG_DEST_CALL, rand_call());
        stage(REG_SRC_LEN, with_junk(48'($urandom_range(0, 7)), LEN_W));
        stage(REG_DEST_SSID, with_junk(48'($urandom_range(0, 15)), SSID_W));
        stage(REG_SRC_CALL, rand_call());
        stage(REG_DEST_LEN, with_junk(48'($urandom_range(0, 7)), LEN_W));
        stage($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, rand_call());
      end
      apply_writes();
      if (p == SQUEEZE_PHASE) begin
        squeeze_req <= 1'b1;
      end
      queue_random_words(WORDS_PER_PHASE);
    end

    drain();
    repeat (40) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/axuhf_pkg.sv
rtl/axuhf_if.sv
rtl/axuhf_ctrl.sv
rtl/axuhf_dp.sv
rtl/ax25_ui_header_framer_top.sv
verif/ax25_ui_header_framer_top_tb.sv
